>>> sv/cartridge_bank_mapper_irq_assert.svh
// Assertion macros for the cartridge bank mapper checker.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cbm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cbm assertion failed");

`endif

>>> sv/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by every RTL module of the block.
package cbm_pkg;

    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PRG_W     = 9;
    localparam int unsigned CHR2K_W   = 7;
    localparam int unsigned CHR1K_W   = 8;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned CHR_SLOTS = 6;

    localparam logic [ADDR_W-1:0] ADDR_DECODE_MASK = 16'hF001;
    localparam logic [ADDR_W-1:0] STATUS_ADDR_LO   = 16'h6000;
    localparam logic [ADDR_W-1:0] STATUS_ADDR_HI   = 16'h7FFF;
    localparam logic [DATA_W-1:0] PRG_SLOT_MASK    = 8'h1F;
    localparam logic [DATA_W-1:0] PRG16_MODE_MASK_RST = 8'h80;
    localparam logic [DATA_W-1:0] PRG16_BANK_MASK_RST = 8'h0F;
    localparam logic [DATA_W-1:0] PRG_SLOT1_RST       = 8'h01;

    // Decoded register codes (address AND F001)
    typedef enum logic [ADDR_W-1:0] {
        DEC_BANK_SELECT = 16'h8000,
        DEC_BANK_DATA   = 16'h8001,
        DEC_MIRROR      = 16'hA000,
        DEC_IRQ_LATCH   = 16'hC000,
        DEC_IRQ_RELOAD  = 16'hC001,
        DEC_IRQ_DISABLE = 16'hE000,
        DEC_IRQ_ENABLE  = 16'hE001
    } decode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOUR_SCREEN     = 2'd0,
        CFG_PRG16_MODE_MASK = 2'd1,
        CFG_PRG16_BANK_MASK = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

    typedef struct packed {
        command_t          command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [PRG_W-1:0]   prg_bank_low;
        logic [PRG_W-1:0]   prg_bank_high;
        logic [CHR2K_W-1:0] chr_bank_2k_first;
        logic [CHR2K_W-1:0] chr_bank_2k_second;
        logic [CHR1K_W-1:0] chr_bank_1k_a;
        logic [CHR1K_W-1:0] chr_bank_1k_b;
        logic [CHR1K_W-1:0] chr_bank_1k_c;
        logic [CHR1K_W-1:0] chr_bank_1k_d;
        logic               nametable_horiz;
        logic               irq_pulse;
    } result_t;

endpackage

>>> sv/cartridge_bank_mapper_irq.sv
// Cartridge bank mapper with scanline IRQ counter, top level.
// Path: an accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while m_ready is high; the output register
// holds a result while the input register takes the next transaction.
// Reset: aresetn synchronous, active low; clears state and config to defaults.
// Depends on cbm_pkg, cbm_in_stage and cbm_core.
module cartridge_bank_mapper_irq
    import cbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [ADDR_W-1:0]    s_address,
    input  logic [DATA_W-1:0]    s_data,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PRG_W-1:0]     m_prg_bank_low,
    output logic [PRG_W-1:0]     m_prg_bank_high,
    output logic [CHR2K_W-1:0]   m_chr_bank_2k_first,
    output logic [CHR2K_W-1:0]   m_chr_bank_2k_second,
    output logic [CHR1K_W-1:0]   m_chr_bank_1k_a,
    output logic [CHR1K_W-1:0]   m_chr_bank_1k_b,
    output logic [CHR1K_W-1:0]   m_chr_bank_1k_c,
    output logic [CHR1K_W-1:0]   m_chr_bank_1k_d,
    output logic                 m_nametable_horiz,
    output logic                 m_irq_pulse
);

    item_t   s_item, item;
    logic    item_valid;
    logic    advance;
    result_t result;

    assign s_item = {s_command, s_address, s_data};

    cbm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cbm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (item),
        .result    (result)
    );

    // Result register: loads when empty or when the held result is taken
    logic    m_valid_reg, m_valid_next;
    result_t result_reg;

    assign advance = item_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_prg_bank_low       = result_reg.prg_bank_low;
    assign m_prg_bank_high      = result_reg.prg_bank_high;
    assign m_chr_bank_2k_first  = result_reg.chr_bank_2k_first;
    assign m_chr_bank_2k_second = result_reg.chr_bank_2k_second;
    assign m_chr_bank_1k_a      = result_reg.chr_bank_1k_a;
    assign m_chr_bank_1k_b      = result_reg.chr_bank_1k_b;
    assign m_chr_bank_1k_c      = result_reg.chr_bank_1k_c;
    assign m_chr_bank_1k_d      = result_reg.chr_bank_1k_d;
    assign m_nametable_horiz    = result_reg.nametable_horiz;
    assign m_irq_pulse          = result_reg.irq_pulse;

endmodule

>>> sv/cbm_in_stage.sv
// Input register stage of the cartridge bank mapper.
// Depends on cbm_pkg for the item type.
module cbm_in_stage
    import cbm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg, valid_next;
    item_t item_reg;

    // Take a new transaction when empty or when the held one moves on
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/cbm_core.sv
// Mapper state: config registers, write decode, IRQ counter, bank mapping.
// Depends on cbm_pkg for types, decode codes and reset constants.
module cbm_core
    import cbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 fire,
    input  item_t                item,
    output result_t              result
);

    // Configuration registers
    logic              four_screen_reg;
    logic [DATA_W-1:0] mode_mask_reg;
    logic [DATA_W-1:0] bank_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            four_screen_reg <= 1'b0;
            mode_mask_reg   <= PRG16_MODE_MASK_RST;
            bank_mask_reg   <= PRG16_BANK_MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FOUR_SCREEN:     four_screen_reg <= cfg_wdata[0];
                CFG_PRG16_MODE_MASK: mode_mask_reg   <= cfg_wdata;
                CFG_PRG16_BANK_MASK: bank_mask_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Mapper state
    logic [2:0]        bank_sel_reg, bank_sel_next;
    logic [DATA_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] prg_reg [2];
    logic [DATA_W-1:0] prg_next [2];
    logic [DATA_W-1:0] chr_reg [CHR_SLOTS];
    logic [DATA_W-1:0] chr_next [CHR_SLOTS];
    logic              mirror_reg, mirror_next;
    logic [CNT_W-1:0]  latch_reg, latch_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              irq_en_reg, irq_en_next;
    logic              pulse;

    // Apply one transaction: tick or CPU write
    always_comb begin
        bank_sel_next = bank_sel_reg;
        status_next   = status_reg;
        prg_next      = prg_reg;
        chr_next      = chr_reg;
        mirror_next   = mirror_reg;
        latch_next    = latch_reg;
        cnt_next      = cnt_reg;
        irq_en_next   = irq_en_reg;
        pulse         = 1'b0;
        if (fire) begin
            if (item.command == CMD_TICK) begin
                // Counter at zero reloads; the IRQ fires only if enabled
                if (cnt_reg == '0) begin
                    cnt_next = latch_reg;
                    pulse    = irq_en_reg;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end else if (item.address >= STATUS_ADDR_LO) begin
                if (item.address <= STATUS_ADDR_HI) begin
                    status_next = item.data;
                end else begin
                    unique case (decode_t'(item.address & ADDR_DECODE_MASK))
                        DEC_BANK_SELECT: bank_sel_next = item.data[2:0];
                        DEC_BANK_DATA: begin
                            if (bank_sel_reg < 3'(CHR_SLOTS)) begin
                                chr_next[bank_sel_reg] = item.data;
                            end else begin
                                prg_next[bank_sel_reg[0]] = item.data;
                            end
                        end
                        DEC_MIRROR: begin
                            if (!four_screen_reg) begin
                                mirror_next = item.data[0];
                            end
                        end
                        DEC_IRQ_LATCH:   latch_next  = item.data;
                        DEC_IRQ_RELOAD:  cnt_next    = latch_reg;
                        DEC_IRQ_DISABLE: irq_en_next = 1'b0;
                        DEC_IRQ_ENABLE:  irq_en_next = 1'b1;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_sel_reg <= '0;
            status_reg   <= '0;
            prg_reg[0]   <= '0;
            prg_reg[1]   <= PRG_SLOT1_RST;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                chr_reg[i] <= '0;
            end
            mirror_reg   <= 1'b0;
            latch_reg    <= '0;
            cnt_reg      <= '0;
            irq_en_reg   <= 1'b0;
        end else begin
            bank_sel_reg <= bank_sel_next;
            status_reg   <= status_next;
            prg_reg      <= prg_next;
            chr_reg      <= chr_next;
            mirror_reg   <= mirror_next;
            latch_reg    <= latch_next;
            cnt_reg      <= cnt_next;
            irq_en_reg   <= irq_en_next;
        end
    end

    // Bank mapping after the transaction; 16K mode overrides both PRG slots
    logic              prg16;
    logic [DATA_W-1:0] bank16;

    assign prg16  = |(status_next & mode_mask_reg);
    assign bank16 = status_next & bank_mask_reg;

    always_comb begin
        if (prg16) begin
            result.prg_bank_low  = {bank16, 1'b0};
            result.prg_bank_high = {bank16, 1'b1};
        end else begin
            result.prg_bank_low  = {1'b0, prg_next[0] & PRG_SLOT_MASK};
            result.prg_bank_high = {1'b0, prg_next[1] & PRG_SLOT_MASK};
        end
        result.chr_bank_2k_first  = chr_next[0][DATA_W-1:1];
        result.chr_bank_2k_second = chr_next[1][DATA_W-1:1];
        result.chr_bank_1k_a      = chr_next[2];
        result.chr_bank_1k_b      = chr_next[3];
        result.chr_bank_1k_c      = chr_next[4];
        result.chr_bank_1k_d      = chr_next[5];
        result.nametable_horiz    = four_screen_reg ? 1'b0 : mirror_next;
        result.irq_pulse          = pulse;
    end

endmodule

>>> sv/cbm_checker.sv
// Port-level checker for the cartridge bank mapper, bound to the top level.
// Depends on cartridge_bank_mapper_irq_assert.svh for the assertion macros.
`include "cartridge_bank_mapper_irq_assert.svh"

module cbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [8:0] m_prg_bank_low,
    input logic [8:0] m_prg_bank_high,
    input logic [6:0] m_chr_bank_2k_first,
    input logic [6:0] m_chr_bank_2k_second,
    input logic [7:0] m_chr_bank_1k_a,
    input logic [7:0] m_chr_bank_1k_b,
    input logic [7:0] m_chr_bank_1k_c,
    input logic [7:0] m_chr_bank_1k_d,
    input logic       m_nametable_horiz,
    input logic       m_irq_pulse
);

    // All result fields in one vector
    logic [65:0] result_fields;
    logic        prg_slot_shape;
    logic        prg_pair_shape;

    assign result_fields = {m_prg_bank_low, m_prg_bank_high,
                            m_chr_bank_2k_first, m_chr_bank_2k_second,
                            m_chr_bank_1k_a, m_chr_bank_1k_b,
                            m_chr_bank_1k_c, m_chr_bank_1k_d,
                            m_nametable_horiz, m_irq_pulse};

    // Two 5-bit slots, or an even/odd 16K pair
    assign prg_slot_shape = (m_prg_bank_low[8:5] == 4'd0) && (m_prg_bank_high[8:5] == 4'd0);
    assign prg_pair_shape = (m_prg_bank_low[0] == 1'b0) && (m_prg_bank_high[0] == 1'b1)
                            && (m_prg_bank_high[8:1] == m_prg_bank_low[8:1]);

    // A stalled result holds all of its fields
    `CBM_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(result_fields))

    // With the result register empty, the input side never stalls
    `CBM_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)

    // PRG banks are either two 5-bit slots or an even/odd 16K pair
    `CBM_ASSERT_NOW(a_prg_shape, m_valid, prg_slot_shape || prg_pair_shape)

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (.*);
